// File: hw/rtl/tccc_pkg.sv
`timescale 1ns / 1ps

package tccc_pkg;

   localparam logic [1:0] ACT_NONE  = 2'd0;
   localparam logic [1:0] ACT_GLYPH = 2'd1;
   localparam logic [1:0] ACT_SPACE = 2'd2;
   localparam logic [1:0] ACT_CLEAR = 2'd3;

   localparam logic [7:0] CHAR_BS    = 8'h08;
   localparam logic [7:0] CHAR_LF    = 8'h0a;
   localparam logic [7:0] CHAR_FF    = 8'h0c;
   localparam logic [7:0] CHAR_CR    = 8'h0d;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TILDE = 8'h7e;

   localparam logic [7:0] COLS_RESET = 8'd80;
   localparam logic [7:0] ROWS_RESET = 8'd50;

   localparam logic CSR_TEXT_COLUMNS = 1'b0;
   localparam logic CSR_TEXT_ROWS    = 1'b1;

   typedef struct packed {
      logic [1:0] draw_action;
      logic [7:0] glyph_code;
      logic [7:0] plot_col;
      logic [7:0] plot_row;
      logic       erase_old_cursor;
      logic       hide_cursor;
      logic       scroll_up;
      logic [7:0] cursor_col;
      logic [7:0] cursor_row;
   } result_type;

endpackage

// File: hw/rtl/text_console_cursor_control_unit.sv
`timescale 1ns / 1ps

// channel   direction  handshake            payload
// req       in         req_valid/req_ready  req_char_byte
// rsp       out        rsp_valid/rsp_ready  rsp_draw_action .. rsp_cursor_row
// csr       in         csr_write_enable     csr_index, csr_write_data
//
// one byte per cycle sustained while rsp is not stalled; from req to rsp a byte passes
// through the input register, then the result register
// the cursor updates as a byte moves from the input register into the result register
// synchronous reset: cursor at (0,0), 80 columns, 50 rows, both stages empty
// a stalled rsp holds the result; the input register still takes one more transaction

module text_console_cursor_control_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_draw_action,
   output logic [7:0] rsp_glyph_code,
   output logic [7:0] rsp_plot_col,
   output logic [7:0] rsp_plot_row,
   output logic       rsp_erase_old_cursor,
   output logic       rsp_hide_cursor,
   output logic       rsp_scroll_up,
   output logic [7:0] rsp_cursor_col,
   output logic [7:0] rsp_cursor_row,
   input  logic       csr_write_enable,
   input  logic       csr_index,
   input  logic [7:0] csr_write_data
);

   logic                 in_valid_ff;
   logic [7:0]           in_char_ff;
   logic                 out_valid_ff;
   tccc_pkg::result_type out_ff;
   logic [7:0]           cols_ff;
   logic [7:0]           rows_ff;
   logic [7:0]           col_ff;
   logic [7:0]           row_ff;
   tccc_pkg::result_type step_in;
   logic                 advance;

   tccc_step u_step (
      .char_byte    (in_char_ff),
      .cur_col      (col_ff),
      .cur_row      (row_ff),
      .text_columns (cols_ff),
      .text_rows    (rows_ff),
      .result       (step_in)
   );

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         cols_ff      <= tccc_pkg::COLS_RESET;
         rows_ff      <= tccc_pkg::ROWS_RESET;
         col_ff       <= 8'd0;
         row_ff       <= 8'd0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            col_ff       <= step_in.cursor_col;
            row_ff       <= step_in.cursor_row;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_write_enable) begin
            if (csr_index == tccc_pkg::CSR_TEXT_COLUMNS) begin
               cols_ff <= csr_write_data;
            end else begin
               rows_ff <= csr_write_data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_char_ff <= req_char_byte;
      end
      if (advance) begin
         out_ff <= step_in;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_draw_action      = out_ff.draw_action;
   assign rsp_glyph_code       = out_ff.glyph_code;
   assign rsp_plot_col         = out_ff.plot_col;
   assign rsp_plot_row         = out_ff.plot_row;
   assign rsp_erase_old_cursor = out_ff.erase_old_cursor;
   assign rsp_hide_cursor      = out_ff.hide_cursor;
   assign rsp_scroll_up        = out_ff.scroll_up;
   assign rsp_cursor_col       = out_ff.cursor_col;
   assign rsp_cursor_row       = out_ff.cursor_row;

endmodule

// File: hw/rtl/tccc_step.sv
`timescale 1ns / 1ps

module tccc_step (
   input  logic [7:0]           char_byte,
   input  logic [7:0]           cur_col,
   input  logic [7:0]           cur_row,
   input  logic [7:0]           text_columns,
   input  logic [7:0]           text_rows,
   output tccc_pkg::result_type result
);

   logic [7:0] cols;
   logic [7:0] rows;
   logic [7:0] col;
   logic [7:0] row;
   logic [8:0] col_inc;
   logic [8:0] row_next;

   assign cols    = (text_columns == 8'd0) ? 8'd1 : text_columns;
   assign rows    = (text_rows == 8'd0) ? 8'd1 : text_rows;
   assign col     = (cur_col >= cols) ? cols - 8'd1 : cur_col;
   assign row     = (cur_row >= rows) ? rows - 8'd1 : cur_row;
   assign col_inc = {1'b0, col} + 9'd1;

   always_comb begin
      result = '0;
      result.cursor_col = col;
      row_next = {1'b0, row};
      case (char_byte) inside
         [tccc_pkg::CHAR_SPACE:tccc_pkg::CHAR_TILDE]: begin
            result.draw_action = tccc_pkg::ACT_GLYPH;
            result.glyph_code  = char_byte;
            result.plot_col    = col;
            result.plot_row    = row;
            result.hide_cursor = 1'b1;
            if (col_inc >= {1'b0, cols}) begin
               result.cursor_col = 8'd0;
               row_next = {1'b0, row} + 9'd1;
            end else begin
               result.cursor_col = col_inc[7:0];
            end
         end
         tccc_pkg::CHAR_BS: begin
            result.erase_old_cursor = 1'b1;
            if (col != 8'd0) begin
               result.cursor_col = col - 8'd1;
            end else if (row != 8'd0) begin
               result.cursor_col = cols - 8'd1;
               row_next = {1'b0, row - 8'd1};
            end
            result.draw_action = tccc_pkg::ACT_SPACE;
            result.glyph_code  = tccc_pkg::CHAR_SPACE;
            result.plot_col    = result.cursor_col;
            result.plot_row    = row_next[7:0];
         end
         tccc_pkg::CHAR_LF: begin
            result.erase_old_cursor = 1'b1;
            row_next = {1'b0, row} + 9'd1;
         end
         tccc_pkg::CHAR_CR: begin
            result.erase_old_cursor = 1'b1;
            result.cursor_col = 8'd0;
         end
         tccc_pkg::CHAR_FF: begin
            result.draw_action = tccc_pkg::ACT_CLEAR;
            result.hide_cursor = 1'b1;
            result.cursor_col  = 8'd0;
            row_next = 9'd0;
         end
         default: begin
            result.draw_action = tccc_pkg::ACT_NONE;
         end
      endcase
      if (row_next >= {1'b0, rows}) begin
         result.cursor_row = rows - 8'd1;
         result.scroll_up  = 1'b1;
      end else begin
         result.cursor_row = row_next[7:0];
      end
   end

endmodule
